>>> rtl/piecewise_linear_table_interp_macros.svh
// assertion macros for the checker file
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PLTI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plti check failed");

// next-cycle implication, checked out of reset
`define PLTI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plti check failed");

`endif

>>> rtl/plti_pkg.sv
// types, constants and codes of the piecewise linear table interpolator
package plti_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int ANGLE_SCALE = 1000;
  localparam int IDX_W       = $clog2(MAX_ROWS);
  localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
  localparam int CNT_W       = 7;
  localparam int ANGLE_W     = 32;
  localparam int RANGE_W     = 16;
  localparam int PROD_W      = ANGLE_W + RANGE_W;
  localparam int DIV_W       = PROD_W + 1;
  localparam int DCNT_W      = $clog2(DIV_W);

  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT_RST = ANGLE_W'(300 * ANGLE_SCALE);

  // floor(x / 5) = (x * 52429) >> 18 for x below 2^17
  localparam logic [RANGE_W-1:0] RND_RECIP = 16'd52429;
  localparam int                 RND_SHIFT = 18;
  localparam logic [RANGE_W-1:0] RANGE_MAX = 16'hFFFF;

  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_ROW   = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ST_WITHIN = 2'd0;
  localparam logic [1:0] ST_BELOW  = 2'd1;
  localparam logic [1:0] ST_ABOVE  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW,
    S_Q_LO,
    S_Q_HI,
    S_SCAN,
    S_MUL,
    S_DLOAD,
    S_DIV,
    S_ADD,
    S_RMUL,
    S_RND
  } plti_state_t;

endpackage

>>> rtl/piecewise_linear_table_interp.sv
// piecewise linear range table: row loading, segment search and serial interpolation
//
// Input words are taken with start while busy is low. One result word per input word
// appears on the out_ ports for exactly one cycle, marked by out_valid; the receiver
// cannot stall it. out_row_total and out_table_ready follow the stored row count.
// Begin words and unused request codes give their result in the cycle after acceptance.
// A row word does one table read of the last angle, then check and append.
// A query answers from idle for a table of fewer than two rows, after the first-row
// check for an angle under the first row and after the last-row check for one past
// the last row. Otherwise it does two table reads for the end rows, a linear search
// that reads one row per step over at most MAX_ROWS rows, one pass through the shared
// 32x16 multiplier, 49 restoring division steps and rounding in the add, multiply
// and round states that reuses the same multiplier. The angle limit register is
// written over the cfg_ channel, always ready; the user must write it only while idle,
// which the block does not enforce. Synchronous reset empties the table (row count
// zero, loading open), sets the limit to 300 degrees in raw units; memory is not cleared.
module piecewise_linear_table_interp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_req_type,
  input  logic [plti_pkg::RANGE_W-1:0]  in_row_range,
  input  logic [plti_pkg::ANGLE_W-1:0]  in_row_angle_raw,
  input  logic [plti_pkg::ANGLE_W-1:0]  in_target_angle_raw,
  output logic                          out_valid,
  output logic [plti_pkg::RANGE_W-1:0]  out_range_out,
  output logic [1:0]                    out_range_status,
  output logic                          out_row_accepted,
  output logic [plti_pkg::CNT_W-1:0]    out_row_total,
  output logic                          out_table_ready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plti_pkg::ANGLE_W-1:0]  cfg_angle_limit_raw
);
  import plti_pkg::*;

  plti_state_t state_r, state_nxt;

  logic [ROWS_W-1:0]  rows_r, rows_nxt;
  logic               closed_r, closed_nxt;
  logic [ANGLE_W-1:0] limit_r;

  logic [1:0]         req_r, req_nxt;
  logic [RANGE_W-1:0] row_rng_r, row_rng_nxt;
  logic [ANGLE_W-1:0] row_ang_r, row_ang_nxt;
  logic [ANGLE_W-1:0] tgt_r, tgt_nxt;

  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [ANGLE_W-1:0] a1_r, a1_nxt;
  logic [RANGE_W-1:0] r1_r, r1_nxt;
  logic [ANGLE_W-1:0] den_r, den_nxt;
  logic               neg_r, neg_nxt;
  logic [ANGLE_W-1:0] op_a_r, op_a_nxt;
  logic [RANGE_W-1:0] op_b_r, op_b_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic [DIV_W-1:0]   div_r, div_nxt;
  logic [ANGLE_W-1:0] rem_r, rem_nxt;
  logic [DCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RANGE_W-1:0] v_r, v_nxt;

  logic               strobe_r, strobe_nxt;
  logic [RANGE_W-1:0] res_range_r, res_range_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic               res_acc_r, res_acc_nxt;

  logic [RANGE_W-1:0] range_mem [MAX_ROWS];
  logic [ANGLE_W-1:0] angle_mem [MAX_ROWS];
  logic [RANGE_W-1:0] rng_q_r;
  logic [ANGLE_W-1:0] ang_q_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;

  logic               accept;
  logic               t_lt, t_gt, scan_more, row_ok, div_last, few_rows;
  logic [ANGLE_W:0]   rem_sh, rem_sub;
  logic               rem_ge;
  logic [RANGE_W:0]   v_sum;
  logic [RANGE_W:0]   q5;
  logic [RANGE_W+2:0] mul5;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  assign t_lt      = (tgt_r < ang_q_r);
  assign t_gt      = (tgt_r > ang_q_r);
  assign scan_more = (j_r == '0) | t_gt;
  assign few_rows  = (rows_r < ROWS_W'(2));
  assign div_last  = (cnt_r == DCNT_W'(DIV_W - 1));

  assign row_ok = ~closed_r & (rows_r < ROWS_W'(MAX_ROWS)) & ~(row_ang_r > limit_r) &
                  ~((rows_r != '0) & (row_ang_r <= ang_q_r));

  // one restoring division step
  assign rem_sh  = {rem_r, div_r[DIV_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};

  assign v_sum = neg_r ? ({1'b0, r1_r} - {1'b0, div_r[RANGE_W-1:0]})
                       : ({1'b0, r1_r} + {1'b0, div_r[RANGE_W-1:0]});
  assign q5    = prod_r[RND_SHIFT +: (RANGE_W + 1)];
  assign mul5  = {q5, 2'b00} + {2'b00, q5};

  assign out_valid        = strobe_r;
  assign out_range_out    = res_range_r;
  assign out_range_status = res_status_r;
  assign out_row_accepted = res_acc_r;
  assign out_row_total    = CNT_W'(rows_r);
  assign out_table_ready  = ~few_rows;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_ROW:   state_nxt = S_ROW;
            REQ_QUERY: state_nxt = few_rows ? S_IDLE : S_Q_LO;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ROW:   state_nxt = S_IDLE;
      S_Q_LO:  state_nxt = t_lt ? S_IDLE : S_Q_HI;
      S_Q_HI:  state_nxt = t_gt ? S_IDLE : S_SCAN;
      S_SCAN:  state_nxt = scan_more ? S_SCAN : S_MUL;
      S_MUL:   state_nxt = S_DLOAD;
      S_DLOAD: state_nxt = S_DIV;
      S_DIV:   state_nxt = div_last ? S_ADD : S_DIV;
      S_ADD:   state_nxt = S_RMUL;
      S_RMUL:  state_nxt = S_RND;
      S_RND:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    rows_nxt       = rows_r;
    closed_nxt     = closed_r;
    req_nxt        = req_r;
    row_rng_nxt    = row_rng_r;
    row_ang_nxt    = row_ang_r;
    tgt_nxt        = tgt_r;
    j_nxt          = j_r;
    a1_nxt         = a1_r;
    r1_nxt         = r1_r;
    den_nxt        = den_r;
    neg_nxt        = neg_r;
    op_a_nxt       = op_a_r;
    op_b_nxt       = op_b_r;
    div_nxt        = div_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    v_nxt          = v_r;
    strobe_nxt     = 1'b0;
    res_range_nxt  = res_range_r;
    res_status_nxt = res_status_r;
    res_acc_nxt    = res_acc_r;
    mem_we         = 1'b0;
    rd_addr        = '0;
    case (state_r)
      S_IDLE: begin
        rd_addr = (in_req_type == REQ_ROW) ? IDX_W'(rows_r - 1'b1) : '0;
        if (accept) begin
          req_nxt        = in_req_type;
          row_rng_nxt    = in_row_range;
          row_ang_nxt    = in_row_angle_raw;
          tgt_nxt        = in_target_angle_raw;
          res_range_nxt  = '0;
          res_status_nxt = ST_WITHIN;
          res_acc_nxt    = 1'b0;
          case (in_req_type)
            REQ_BEGIN: begin
              rows_nxt   = '0;
              closed_nxt = 1'b0;
              strobe_nxt = 1'b1;
            end
            REQ_ROW: begin
            end
            REQ_QUERY: begin
              if (few_rows) begin
                res_range_nxt  = RANGE_MAX;
                res_status_nxt = ST_ABOVE;
                strobe_nxt     = 1'b1;
              end
            end
            default: strobe_nxt = 1'b1;
          endcase
        end
      end
      S_ROW: begin
        // ang_q_r holds the last stored angle
        strobe_nxt  = 1'b1;
        res_acc_nxt = row_ok;
        if (row_ok) begin
          mem_we     = 1'b1;
          rows_nxt   = ROWS_W'(rows_r + 1'b1);
          closed_nxt = (ROWS_W'(rows_r + 1'b1) >= ROWS_W'(MAX_ROWS));
        end else begin
          closed_nxt = 1'b1;
        end
      end
      S_Q_LO: begin
        rd_addr = IDX_W'(rows_r - 1'b1);
        if (t_lt) begin
          res_range_nxt  = '0;
          res_status_nxt = ST_BELOW;
          strobe_nxt     = 1'b1;
        end
      end
      S_Q_HI: begin
        j_nxt = '0;
        if (t_gt) begin
          res_range_nxt  = RANGE_MAX;
          res_status_nxt = ST_ABOVE;
          strobe_nxt     = 1'b1;
        end
      end
      S_SCAN: begin
        rd_addr = IDX_W'(j_r + 1'b1);
        if (scan_more) begin
          a1_nxt = ang_q_r;
          r1_nxt = rng_q_r;
          j_nxt  = IDX_W'(j_r + 1'b1);
        end else begin
          // segment found: a1_r..ang_q_r brackets the target
          den_nxt  = ang_q_r - a1_r;
          op_a_nxt = tgt_r - a1_r;
          neg_nxt  = (rng_q_r < r1_r);
          op_b_nxt = (rng_q_r < r1_r) ? (r1_r - rng_q_r) : (rng_q_r - r1_r);
        end
      end
      S_MUL: begin
      end
      S_DLOAD: begin
        // falling segment rounds the quotient up
        div_nxt = neg_r ? (DIV_W'(prod_r) + DIV_W'(den_r) - 1'b1) : DIV_W'(prod_r);
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      S_DIV: begin
        rem_nxt = rem_ge ? rem_sub[ANGLE_W-1:0] : rem_sh[ANGLE_W-1:0];
        div_nxt = {div_r[DIV_W-2:0], rem_ge};
        cnt_nxt = DCNT_W'(cnt_r + 1'b1);
      end
      S_ADD: begin
        v_nxt    = v_sum[RANGE_W-1:0];
        op_a_nxt = ANGLE_W'(v_sum + 2'd2);
        op_b_nxt = RND_RECIP;
      end
      S_RMUL: begin
      end
      S_RND: begin
        res_range_nxt  = ((v_r == '0) || (v_r == RANGE_MAX)) ? v_r : mul5[RANGE_W-1:0];
        res_status_nxt = ST_WITHIN;
        strobe_nxt     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rows_r   <= '0;
      closed_r <= 1'b0;
      limit_r  <= ANGLE_LIMIT_RST;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rows_r   <= rows_nxt;
      closed_r <= closed_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_angle_limit_raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    row_rng_r    <= row_rng_nxt;
    row_ang_r    <= row_ang_nxt;
    tgt_r        <= tgt_nxt;
    j_r          <= j_nxt;
    a1_r         <= a1_nxt;
    r1_r         <= r1_nxt;
    den_r        <= den_nxt;
    neg_r        <= neg_nxt;
    op_a_r       <= op_a_nxt;
    op_b_r       <= op_b_nxt;
    prod_r       <= op_a_r * op_b_r;
    div_r        <= div_nxt;
    rem_r        <= rem_nxt;
    cnt_r        <= cnt_nxt;
    v_r          <= v_nxt;
    res_range_r  <= res_range_nxt;
    res_status_r <= res_status_nxt;
    res_acc_r    <= res_acc_nxt;
  end

  // row table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we && (req_r == REQ_ROW)) begin
      range_mem[IDX_W'(rows_r)] <= row_rng_r;
      angle_mem[IDX_W'(rows_r)] <= row_ang_r;
    end
    rng_q_r <= range_mem[rd_addr];
    ang_q_r <= angle_mem[rd_addr];
  end

endmodule

>>> rtl/plti_checker.sv
// port-level checks for the piecewise linear table interpolator
`include "piecewise_linear_table_interp_macros.svh"

module plti_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [plti_pkg::RANGE_W-1:0]  out_range_out,
  input logic [1:0]                    out_range_status,
  input logic [plti_pkg::CNT_W-1:0]    out_row_total
);
  import plti_pkg::*;

  // an accepted word either keeps the block busy or is answered at once
  `PLTI_ASSERT_NXT(a_accept_answered, start && !busy, busy || out_valid)
  // results only leave on the way back to idle
  `PLTI_ASSERT_NOW(a_valid_idle, out_valid, !busy)
  `PLTI_ASSERT_NOW(a_below_zero, out_valid && (out_range_status == ST_BELOW),
                   out_range_out == '0)
  `PLTI_ASSERT_NOW(a_above_max, out_valid && (out_range_status == ST_ABOVE),
                   out_range_out == RANGE_MAX)
  `PLTI_ASSERT_NOW(a_rows_bound, 1'b1, out_row_total <= CNT_W'(MAX_ROWS))

endmodule

bind piecewise_linear_table_interp plti_checker u_plti_checker (.*);

>>> dv/piecewise_linear_table_interp_tb.sv
// self-checking testbench for the piecewise linear range table interpolator
module piecewise_linear_table_interp_tb;
  import plti_pkg::*;

  localparam logic [1:0] REQ_SPARE   = 2'd3;
  localparam int         STALL_LIMIT = 4000;
  localparam int         ROUND_STEP  = 5;

  typedef struct packed {
    logic [1:0]         req;
    logic [RANGE_W-1:0] row_range;
    logic [ANGLE_W-1:0] row_angle;
    logic [ANGLE_W-1:0] target;
  } table_word_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_m;
    logic [1:0]         status;
    logic               row_acc;
    logic [CNT_W-1:0]   rows;
    logic               ready;
  } table_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_req_type = REQ_BEGIN;
  logic [RANGE_W-1:0] in_row_range = '0;
  logic [ANGLE_W-1:0] in_row_angle_raw = '0;
  logic [ANGLE_W-1:0] in_target_angle_raw = '0;
  logic               out_valid;
  logic [RANGE_W-1:0] out_range_out;
  logic [1:0]         out_range_status;
  logic               out_row_accepted;
  logic [CNT_W-1:0]   out_row_total;
  logic               out_table_ready;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ANGLE_W-1:0] cfg_angle_limit_raw = '0;

  // predicted table contents and settings
  logic [RANGE_W-1:0] tbl_range [MAX_ROWS];
  logic [ANGLE_W-1:0] tbl_angle [MAX_ROWS];
  int unsigned        tbl_rows = 0;
  bit                 tbl_closed = 1'b0;
  logic [ANGLE_W-1:0] tbl_limit = ANGLE_LIMIT_RST;

  table_word_t   pending_words [$];
  table_result_t range_expect_q [$];
  int unsigned   words_queued = 0;
  int unsigned   cfg_writes = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   sender_idle_pct = 0;
  logic          word_taken = 1'b0;

  piecewise_linear_table_interp u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_req_type         (in_req_type),
    .in_row_range        (in_row_range),
    .in_row_angle_raw    (in_row_angle_raw),
    .in_target_angle_raw (in_target_angle_raw),
    .out_valid           (out_valid),
    .out_range_out       (out_range_out),
    .out_range_status    (out_range_status),
    .out_row_accepted    (out_row_accepted),
    .out_row_total       (out_row_total),
    .out_table_ready     (out_table_ready),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_angle_limit_raw (cfg_angle_limit_raw)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // works out the result word of one accepted input word and updates the table
  function automatic table_result_t table_step(input table_word_t w);
    table_result_t r;
    int unsigned   i, r1, r2, v;
    longint unsigned d, den, q;
    bit            hit;
    r = '0;
    case (w.req)
      REQ_BEGIN: begin
        tbl_rows   = 0;
        tbl_closed = 1'b0;
      end
      REQ_ROW: begin
        if (tbl_closed || tbl_rows >= MAX_ROWS) begin
          tbl_closed = 1'b1;
        end else if (w.row_angle > tbl_limit ||
                     (tbl_rows > 0 && w.row_angle <= tbl_angle[tbl_rows-1])) begin
          tbl_closed = 1'b1;
        end else begin
          tbl_range[tbl_rows] = w.row_range;
          tbl_angle[tbl_rows] = w.row_angle;
          tbl_rows++;
          r.row_acc = 1'b1;
          if (tbl_rows >= MAX_ROWS) tbl_closed = 1'b1;
        end
      end
      REQ_QUERY: begin
        r.range_m = RANGE_MAX;
        r.status  = ST_ABOVE;
        if (tbl_rows >= 2) begin
          if (w.target < tbl_angle[0]) begin
            r.range_m = '0;
            r.status  = ST_BELOW;
          end else if (w.target <= tbl_angle[tbl_rows-1]) begin
            hit = 1'b0;
            for (i = 0; i + 1 < tbl_rows && !hit; i++) begin
              if (w.target >= tbl_angle[i] && w.target <= tbl_angle[i+1] &&
                  tbl_angle[i+1] > tbl_angle[i]) begin
                hit = 1'b1;
                d   = 64'(w.target) - 64'(tbl_angle[i]);
                den = 64'(tbl_angle[i+1]) - 64'(tbl_angle[i]);
                r1  = 32'(tbl_range[i]);
                r2  = 32'(tbl_range[i+1]);
                // falling segments round the step up so the value is floored
                if (r2 >= r1) begin
                  q = (d * 64'(r2 - r1)) / den;
                  v = r1 + q[31:0];
                end else begin
                  q = (d * 64'(r1 - r2) + den - 1) / den;
                  v = r1 - q[31:0];
                end
                if (v == 0 || v == RANGE_MAX) r.range_m = v[RANGE_W-1:0];
                else r.range_m = RANGE_W'(((v + 2) / ROUND_STEP) * ROUND_STEP);
                r.status = ST_WITHIN;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.rows  = CNT_W'(tbl_rows);
    r.ready = (tbl_rows >= 2);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got_v,
                               input longint unsigned want_v);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got_v, want_v);
    mismatch_count++;
  endtask

  // driver: presents queued words at the falling edge
  always @(negedge clk) begin
    table_word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        w = pending_words.pop_front();
        start               <= 1'b1;
        in_req_type         <= w.req;
        in_row_range        <= w.row_range;
        in_row_angle_raw    <= w.row_angle;
        in_target_angle_raw <= w.target;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: checks result words, predicts accepted words, watches for stalls
  always @(posedge clk) begin
    table_result_t got, want;
    logic          took;
    if (!rst_n) begin
      word_taken   <= 1'b0;
      stall_cycles <= 0;
    end else begin
      took = start && !busy;
      if (out_valid) begin
        got = '{out_range_out, out_range_status, out_row_accepted, out_row_total,
                out_table_ready};
        if (range_expect_q.size() == 0) begin
          flag_mismatch("unexpected result word", got, 0);
        end else begin
          want = range_expect_q.pop_front();
          if (got.range_m !== want.range_m) flag_mismatch("range_out", got.range_m, want.range_m);
          if (got.status !== want.status) flag_mismatch("range_status", got.status, want.status);
          if (got.row_acc !== want.row_acc) flag_mismatch("row_accepted", got.row_acc, want.row_acc);
          if (got.rows !== want.rows) flag_mismatch("row_total", got.rows, want.rows);
          if (got.ready !== want.ready) flag_mismatch("table_ready", got.ready, want.ready);
        end
      end
      if (took) begin
        range_expect_q.push_back(table_step('{in_req_type, in_row_range, in_row_angle_raw,
                                              in_target_angle_raw}));
      end
      if (cfg_valid && cfg_ready) begin
        tbl_limit = cfg_angle_limit_raw;
        cfg_writes <= cfg_writes + 1;
      end
      word_taken <= took;
      if (out_valid || took || (cfg_valid && cfg_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic queue_word(input logic [1:0] req, input logic [RANGE_W-1:0] rr,
                            input logic [ANGLE_W-1:0] ra, input logic [ANGLE_W-1:0] ta);
    table_word_t w;
    w.req       = req;
    w.row_range = rr;
    w.row_angle = ra;
    w.target    = ta;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // one table session: begin, a run of mostly rising rows, queries mostly inside the table, at times one random word
  task automatic queue_session(input logic [ANGLE_W-1:0] lim);
    int unsigned        n_rows, n_q, i, j, sel;
    longint unsigned    a, step_max, room, t;
    logic [ANGLE_W-1:0] ang [$];
    logic [RANGE_W-1:0] rng;
    logic [ANGLE_W-1:0] bad_angle;
    n_rows = ($urandom_range(0, 11) == 0) ? $urandom_range(62, 66) : $urandom_range(0, 8);
    n_q    = $urandom_range(1, 10);
    case ($urandom_range(0, 3))
      0: step_max = 3;
      1: step_max = 2000;
      2: step_max = 64'd1 << 20;
      default: step_max = 64'd1 << 28;
    endcase
    a    = 64'($urandom) % ((64'(lim) >> 1) + 1);
    room = 64'(lim) - a;
    if (n_rows > 1 && step_max * n_rows > room) step_max = room / n_rows;
    if (step_max == 0) step_max = 1;
    queue_word(REQ_BEGIN, RANGE_W'($urandom), $urandom, $urandom);
    rng = RANGE_W'($urandom);
    for (i = 0; i < n_rows; i++) begin
      if (i > 0) a = a + 1 + 64'($urandom) % step_max;
      rng = ($urandom_range(0, 2) == 0) ? RANGE_W'($urandom)
                                        : rng + RANGE_W'($urandom_range(0, 400)) - RANGE_W'(200);
      if ($urandom_range(0, 29) == 0) begin
        // broken row: repeated or falling angle, past the limit, or anything
        case ($urandom_range(0, 2))
          0: bad_angle = (ang.size() > 0) ? ang[$] - ANGLE_W'($urandom_range(0, 1)) : lim + 1;
          1: bad_angle = lim + 1;
          default: bad_angle = $urandom;
        endcase
        queue_word(REQ_ROW, rng, bad_angle, $urandom);
      end else begin
        queue_word(REQ_ROW, rng, a[ANGLE_W-1:0], $urandom);
        if (a <= 64'(lim)) ang.push_back(a[ANGLE_W-1:0]);
      end
    end
    for (j = 0; j < n_q; j++) begin
      sel = $urandom_range(0, 19);
      if (ang.size() >= 2 && sel < 13) begin
        i = $urandom_range(0, ang.size() - 2);
        t = 64'(ang[i]) + 64'($urandom) % (64'(ang[i+1]) - 64'(ang[i]) + 1);
      end else if (ang.size() > 0 && sel < 15) begin
        t = 64'(ang[$urandom_range(0, ang.size() - 1)]);
      end else if (ang.size() > 0 && sel < 17) begin
        t = (ang[0] == 0) ? 64'd0 : 64'($urandom) % 64'(ang[0]);
      end else if (ang.size() > 0 && sel < 19) begin
        t = 64'(ang[$]) + 1 + 64'($urandom_range(0, 999));
      end else begin
        t = 64'($urandom);
      end
      queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, t[ANGLE_W-1:0]);
    end
    if ($urandom_range(0, 3) == 0) begin
      queue_word(2'($urandom_range(0, 3)), RANGE_W'($urandom), $urandom, $urandom);
    end
  endtask

  task automatic queue_random(input int unsigned n, input logic [ANGLE_W-1:0] lim);
    int unsigned goal;
    goal = words_queued + n;
    while (words_queued < goal) queue_session(lim);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || start || range_expect_q.size() > 0 || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [ANGLE_W-1:0] v);
    int unsigned n;
    n = cfg_writes;
    @(negedge clk);
    cfg_valid           <= 1'b1;
    cfg_angle_limit_raw <= v;
    wait (cfg_writes != n);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [ANGLE_W-1:0] lim;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words under the reset limit
    sender_idle_pct = 31;
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, 32'd0);  // empty table
    queue_word(REQ_SPARE, RANGE_W'($urandom), $urandom, $urandom);
    queue_word(REQ_ROW, 16'd100, 32'd0, $urandom);
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, 32'd0);  // single row, not ready
    queue_word(REQ_ROW, 16'hFFFF, 32'd1000, $urandom);
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, 32'd0);
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, 32'd1000); // exactly full range
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, 32'd999);
    queue_word(REQ_ROW, 16'd0, 32'd2000, $urandom);
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, 32'd2000); // exactly zero
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, 32'd1999); // falling segment
    queue_word(REQ_ROW, 16'd5, 32'd2000, $urandom);            // repeated angle closes loading
    queue_word(REQ_ROW, 16'd10, 32'd3000, $urandom);           // loading closed
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, 32'hFFFF_FFFF);
    queue_word(REQ_BEGIN, RANGE_W'($urandom), $urandom, $urandom);
    queue_word(REQ_ROW, 16'd1, 32'd10, $urandom);
    queue_word(REQ_ROW, 16'd2, 32'd20, $urandom);
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, 32'd9);  // under first row
    queue_word(REQ_ROW, 16'd7, ANGLE_LIMIT_RST + 1, $urandom); // past the limit
    queue_word(REQ_BEGIN, RANGE_W'($urandom), $urandom, $urandom);
    queue_word(REQ_ROW, 16'd0, 32'd0, $urandom);
    queue_word(REQ_ROW, 16'hFFFF, ANGLE_LIMIT_RST, $urandom);  // right at the limit
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, ANGLE_LIMIT_RST - 1);
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, ANGLE_LIMIT_RST - 2);
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, ANGLE_LIMIT_RST / 2);
    queue_word(REQ_QUERY, RANGE_W'($urandom), $urandom, 32'd2);
    wait_drained();

    write_limit(32'hFFFF_FFFF);
    queue_random(480, 32'hFFFF_FFFF);
    wait_drained();

    write_limit(32'd0);
    queue_random(40, 32'd0);
    wait_drained();

    sender_idle_pct = 86;
    lim = $urandom;
    write_limit(lim);
    queue_random(460, lim);
    wait_drained();

    // no idling at all
    sender_idle_pct = 0;
    lim = $urandom_range(1000, 5_000_000);
    write_limit(lim);
    queue_random(460, lim);
    wait_drained();

    repeat (150) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
